FILE: rtl/core/ppds_pkg.sv
package ppds_pkg;

  localparam int unsigned FreqW   = 29;
  localparam int unsigned PixW    = 19;
  localparam int unsigned SpaceW  = 2;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned MCodeW  = 5;
  localparam int unsigned NCodeW  = 8;
  localparam int unsigned PCodeW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MLimitDefault = 64;

  // Candidate n is at most 12 bits (n_max 2048), but with a tiny reference
  // the rounded quotient runs far wider, and so can the rounded clock before
  // saturation. Quotients therefore keep the full dividend width.
  localparam int unsigned QuoW  = 42;
  localparam int unsigned NW    = 12;
  // req*m fits in 29+7 bits; fref*n in 29+12 bits.
  localparam int unsigned ProdW = 42;
  localparam int unsigned ErrW  = 42;

  localparam logic [CfgIdxW-1:0] RegRefFreq  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinVco   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMax8     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMax16    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMax24    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegChipCls  = 3'd5;

  localparam logic [FreqW-1:0] RefFreqReset = 29'd14662;
  localparam logic [FreqW-1:0] FreqMax      = {FreqW{1'b1}};

  localparam logic [SpaceW-1:0] Space8  = 2'd0;
  localparam logic [SpaceW-1:0] Space24 = 2'd3;

  localparam logic [ClassW-1:0] ClassNarrow32 = 2'd0;
  localparam logic [ClassW-1:0] ClassNarrow64 = 2'd1;
  localparam logic [ClassW-1:0] ClassWide     = 2'd2;

  localparam logic [NW-1:0] NMaxNarrow = 12'd128;
  localparam logic [NW-1:0] NMaxWide   = 12'd2048;

  // One division handed down the divider chain.
  typedef struct packed {
    logic             vld;
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  quo;
  } div_cell_t;

endpackage

FILE: rtl/core/pixel_pll_divider_search_top.sv
// Channel   Direction  Handshake          Fields
// in        input      in_valid_i/stall_o pixel_clock_khz_i, colour_space_i
// out       output     out_valid_o/stall_i m_code_o .. search_status_o
// cfg       input      cfg_we_i           cfg_idx_i, cfg_data_i
// Every tried m and the final rounding pass through the 42-cell divider
// chain; a skipped odd m does not. With M_LIMIT 64, 48 values of m are
// tried, and 24 for chip class 0.
// One item is worked on at a time; a new one is taken once the result register
// is free. Reset clears control state and restores register defaults.
// A stalled result holds its values until the output transaction completes.
module pixel_pll_divider_search_top #(
  parameter int unsigned M_LIMIT = ppds_pkg::MLimitDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ppds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ppds_pkg::FreqW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ppds_pkg::PixW-1:0]    pixel_clock_khz_i,
  input  logic [ppds_pkg::SpaceW-1:0]  colour_space_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ppds_pkg::MCodeW-1:0]  m_code_o,
  output logic [ppds_pkg::NCodeW-1:0]  n_code_o,
  output logic [ppds_pkg::PCodeW-1:0]  p_code_o,
  output logic [ppds_pkg::FreqW-1:0]   actual_clock_o,
  output logic                         search_status_o
);
  import ppds_pkg::*;

  localparam int unsigned MW = $clog2(M_LIMIT + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StAct  = 3'd3;
  localparam logic [2:0] StActW = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [FreqW-1:0]  ref_q, minv_q, max8_q, max16_q, max24_q;
  logic [ClassW-1:0] cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= RefFreqReset;
      minv_q  <= '0;
      max8_q  <= FreqMax;
      max16_q <= FreqMax;
      max24_q <= FreqMax;
      cls_q   <= ClassWide;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRefFreq: ref_q   <= cfg_data_i;
        RegMinVco:  minv_q  <= cfg_data_i;
        RegMax8:    max8_q  <= cfg_data_i;
        RegMax16:   max16_q <= cfg_data_i;
        RegMax24:   max24_q <= cfg_data_i;
        RegChipCls: cls_q   <= cfg_data_i[ClassW-1:0];
        default: ;
      endcase
    end
  end

  logic [2:0]       st_q, st_d;
  logic [FreqW-1:0] req_q, req_d;
  logic [MW-1:0]    m_q, m_d, mmax;
  logic [NW-1:0]    nmax;
  logic             found_q, found_d;
  logic [MW-1:0]    bm_q, bm_d;
  logic [NW-1:0]    bn_q, bn_d;
  logic [ErrW-1:0]  be_q, be_d;
  logic             ov_q, ov_d;
  logic [MCodeW-1:0] mc_q, mc_d;
  logic [NCodeW-1:0] nc_q, nc_d;
  logic [PCodeW-1:0] pc_q, pc_d;
  logic [FreqW-1:0]  ac_q, ac_d;
  logic              ss_q, ss_d;

  logic             dv_start;
  logic [ProdW-1:0] dv_num, dv_den;
  logic             dv_done;
  logic [QuoW-1:0]  dv_quo;

  // Comparison and packing are taken from the registered quotient so that
  // the multiplications sit in their own cycle.
  logic [QuoW-1:0]  q_q;
  logic [ProdW-1:0] prod_q, got_q;
  logic             chk_q;
  logic [ProdW-1:0] err;
  logic [ErrW+MW-1:0] lhs, rhs;
  logic             nok;

  ppds_divider #(.NumBits(QuoW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .done_o (dv_done),
    .quo_o  (dv_quo)
  );

  always_comb begin
    mmax = (cls_q == ClassNarrow32) ? MW'(32) : MW'(M_LIMIT);
    nmax = (cls_q == ClassNarrow32 || cls_q == ClassNarrow64) ? NMaxNarrow : NMaxWide;
  end

  always_ff @(posedge clk_i) begin
    q_q    <= dv_quo;
    prod_q <= ProdW'(req_q) * ProdW'(m_q);
    got_q  <= ProdW'(ref_q) * ProdW'(dv_quo[NW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chk_q <= 1'b0;
    else         chk_q <= dv_done && (st_q == StWait || st_q == StActW);
  end

  assign err = (prod_q > got_q) ? prod_q - got_q : got_q - prod_q;
  assign lhs = (ErrW+MW)'(err) * (ErrW+MW)'(bm_q);
  assign rhs = (ErrW+MW)'(be_q) * (ErrW+MW)'(m_q);
  assign nok = q_q >= QuoW'(1) && q_q <= QuoW'(nmax);

  always_comb begin
    logic [FreqW-1:0] maxc, r;
    logic [ProdW-1:0] nc;
    maxc = (colour_space_i == Space8) ? max8_q :
           (colour_space_i == Space24) ? max24_q : max16_q;
    r = {pixel_clock_khz_i, 10'd0};
    st_d = st_q; req_d = req_q; m_d = m_q; found_d = found_q;
    bm_d = bm_q; bn_d = bn_q; be_d = be_q; ov_d = ov_q;
    mc_d = mc_q; nc_d = nc_q; pc_d = pc_q; ac_d = ac_q; ss_d = ss_q;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    nc = ProdW'(bn_q) - ProdW'(1);
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (r < minv_q) r = minv_q;
          if (r > maxc) r = maxc;
          req_d = r; m_d = MW'(1); found_d = 1'b0;
          st_d = (ref_q == '0) ? StAct : StDiv;
        end
      end
      StDiv: begin
        if (m_q > mmax) st_d = StAct;
        else if (m_q > (mmax >> 1) && m_q[0]) m_d = m_q + MW'(1);
        else begin
          dv_start = 1'b1;
          dv_num = (ProdW'(req_q) * ProdW'(m_q) << 1) + ProdW'(ref_q);
          dv_den = ProdW'(ref_q) << 1;
          st_d = StWait;
        end
      end
      StWait: begin
        if (chk_q) begin
          if (nok && (!found_q || lhs < rhs)) begin
            found_d = 1'b1; bm_d = m_q; bn_d = q_q[NW-1:0]; be_d = err;
          end
          m_d = m_q + MW'(1);
          st_d = StDiv;
        end
      end
      StAct: begin
        if (!found_q) begin
          mc_d = '0; nc_d = '0; pc_d = '0; ac_d = '0; ss_d = 1'b1;
          st_d = StOut;
        end else begin
          dv_start = 1'b1;
          dv_num = ((ProdW'(ref_q) * ProdW'(bn_q)) << 1) + ProdW'(bm_q);
          dv_den = ProdW'(bm_q) << 1;
          ov_d = bm_q > (mmax >> 1);
          st_d = StActW;
        end
      end
      StActW: begin
        if (chk_q) begin
          mc_d = ov_q ? MCodeW'((bm_q >> 1) - MW'(1)) : MCodeW'(bm_q - MW'(1));
          if (cls_q == ClassNarrow32 || cls_q == ClassNarrow64) begin
            nc_d = {ov_q, nc[6:0]};
            pc_d = '0;
          end else begin
            nc_d = nc[7:0];
            pc_d = {ov_q, nc[10:8], 4'd0};
          end
          ac_d = (q_q > QuoW'(FreqMax)) ? FreqMax : q_q[FreqW-1:0];
          ss_d = 1'b0;
          st_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; m_q <= '0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; m_q <= m_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; bm_q <= bm_d; bn_q <= bn_d; be_q <= be_d; ov_q <= ov_d;
    mc_q <= mc_d; nc_q <= nc_d; pc_q <= pc_d; ac_q <= ac_d; ss_q <= ss_d;
  end

  assign in_stall_o      = st_q != StIdle;
  assign out_valid_o     = st_q == StOut;
  assign m_code_o        = mc_q;
  assign n_code_o        = nc_q;
  assign p_code_o        = pc_q;
  assign actual_clock_o  = ac_q;
  assign search_status_o = ss_q;

endmodule

FILE: rtl/core/ppds_div_cell.sv
module ppds_div_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ppds_pkg::ProdW-1:0] den_i,
  input  ppds_pkg::div_cell_t     cell_i,
  output ppds_pkg::div_cell_t     cell_o
);
  import ppds_pkg::*;

  // One restoring step per cell: a bit of the dividend has already been
  // brought in, here the trial subtraction decides one quotient bit.
  logic [ProdW:0]   trial;
  div_cell_t        cell_d, cell_q;

  always_comb begin
    trial  = {1'b0, cell_i.rem} - {1'b0, den_i};
    cell_d = cell_i;
    if (!trial[ProdW]) begin
      cell_d.rem = trial[ProdW-1:0];
      cell_d.quo = cell_i.quo | {{(QuoW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
      cell_q.rem <= '0;
      cell_q.quo <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: rtl/core/ppds_divider.sv
module ppds_divider #(
  parameter int unsigned NumBits = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppds_pkg::ProdW-1:0] num_i,
  input  logic [ppds_pkg::ProdW-1:0] den_i,
  output logic                       done_o,
  output logic [ppds_pkg::QuoW-1:0]  quo_o
);
  import ppds_pkg::*;

  // The dividend is fed one bit per cycle into a chain of NumBits cells.
  // Every cell shifts the partial remainder, takes in the next dividend bit
  // and performs one trial subtraction, handing the result to its neighbour.
  localparam int unsigned CntW = $clog2(NumBits + 1);

  div_cell_t             link [NumBits+1];
  div_cell_t             feed [NumBits];
  logic [ProdW-1:0]      num_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [ProdW-1:0]      den_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) cnt_d = CntW'(1);
    else if (cnt_q != '0 && cnt_q != CntW'(NumBits)) cnt_d = cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  assign link[0].vld = 1'b0;
  assign link[0].rem = '0;
  assign link[0].quo = '0;

  for (genvar g = 0; g < NumBits; g++) begin : g_cell
    logic dbit;
    assign dbit = (g == 0) ? 1'b0 : num_q[NumBits-1-g];
    always_comb begin
      feed[g].vld = (g == 0) ? (cnt_q == CntW'(1)) : link[g].vld;
      if (g == 0) begin
        feed[g].rem = {{(ProdW-1){1'b0}}, num_q[NumBits-1]};
        feed[g].quo = '0;
      end else begin
        feed[g].rem = {link[g].rem[ProdW-2:0], dbit};
        feed[g].quo = {link[g].quo[QuoW-2:0], 1'b0};
      end
    end
    ppds_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .den_i (den_q),
      .cell_i(feed[g]),
      .cell_o(link[g+1])
    );
  end

  assign done_o = link[NumBits].vld;
  assign quo_o  = link[NumBits].quo;

endmodule

FILE: rtl/core/ppds_checker.sv
module ppds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ppds_pkg::MCodeW-1:0] m_code_o,
  input logic [ppds_pkg::NCodeW-1:0] n_code_o,
  input logic [ppds_pkg::PCodeW-1:0] p_code_o,
  input logic [ppds_pkg::FreqW-1:0]  actual_clock_o,
  input logic                        search_status_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(actual_clock_o))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && search_status_o |-> m_code_o == '0 && n_code_o == '0 &&
    p_code_o == '0 && actual_clock_o == '0)
    else $error("failed search carries a setting");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("accepted transaction did not start a search");
endmodule

bind pixel_pll_divider_search_top ppds_checker u_ppds_checker (.*);

FILE: tb/sv/tb_pixel_pll_divider_search_top.sv
module tb_pixel_pll_divider_search_top;
  import ppds_pkg::*;

  localparam int unsigned StallLimit = 40000;

  typedef struct packed {
    logic [MCodeW-1:0] m_code;
    logic [NCodeW-1:0] n_code;
    logic [PCodeW-1:0] p_code;
    logic [FreqW-1:0]  actual_clock;
    logic              search_status;
  } pll_setting_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [FreqW-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_clock_khz_i;
  logic [SpaceW-1:0]   colour_space_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [MCodeW-1:0]   m_code_o;
  logic [NCodeW-1:0]   n_code_o;
  logic [PCodeW-1:0]   p_code_o;
  logic [FreqW-1:0]    actual_clock_o;
  logic                search_status_o;

  // Shadow copy of the block's registers.
  logic [FreqW-1:0]  ref_freq_q;
  logic [FreqW-1:0]  min_vco_q;
  logic [FreqW-1:0]  max8_q;
  logic [FreqW-1:0]  max16_q;
  logic [FreqW-1:0]  max24_q;
  logic [ClassW-1:0] class_q;

  pll_setting_t expected_settings[$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  pixel_pll_divider_search_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic pll_setting_t search_divider(logic [PixW-1:0] pix,
                                                  logic [SpaceW-1:0] space);
    longint unsigned req, fref, maxc, n, prod, got, num, best_num, act;
    int unsigned m_max, n_max, m, best_m, best_n, nc, pbit;
    bit found;
    pll_setting_t r;
    req = longint'(pix) << 10;
    fref = ref_freq_q;
    found = 0;
    best_m = 0;
    best_n = 0;
    best_num = 0;
    r = '0;
    if (class_q == ClassNarrow32) begin
      m_max = 32; n_max = 128;
    end else if (class_q == ClassNarrow64) begin
      m_max = MLimitDefault; n_max = 128;
    end else begin
      m_max = MLimitDefault; n_max = 2048;
    end
    if (space == Space8) maxc = max8_q;
    else if (space == Space24) maxc = max24_q;
    else maxc = max16_q;
    if (req < min_vco_q) req = min_vco_q;
    if (req > maxc) req = maxc;
    if (fref != 0) begin
      for (m = 1; m <= m_max; m++) begin
        // Upper half of the range uses the fixed halver, so odd m are out.
        if (m > m_max / 2 && m[0]) continue;
        n = (2 * req * m + fref) / (2 * fref);
        if (n < 1 || n > n_max) continue;
        prod = req * m;
        got = fref * n;
        num = prod > got ? prod - got : got - prod;
        if (!found || num * best_m < best_num * m) begin
          found = 1;
          best_m = m;
          best_n = 32'(n);
          best_num = num;
        end
      end
    end
    if (!found) begin
      r.search_status = 1'b1;
      return r;
    end
    nc = best_n - 1;
    if (best_m <= m_max / 2) begin
      r.m_code = MCodeW'(best_m - 1); pbit = 0;
    end else begin
      r.m_code = MCodeW'(best_m / 2 - 1); pbit = 1 << 7;
    end
    act = (2 * fref * best_n + best_m) / (2 * longint'(best_m));
    if (act > FreqMax) act = FreqMax;
    if (class_q < ClassWide) begin
      r.n_code = NCodeW'((nc & 'h07f) | pbit);
      r.p_code = '0;
    end else begin
      r.n_code = NCodeW'(nc & 'h0ff);
      r.p_code = PCodeW'(((nc & 'h700) >> 4) | pbit);
    end
    r.actual_clock = FreqW'(act);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    pll_setting_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_settings.size() == 0) begin
        report_mismatch("unexpected result, m_code", m_code_o, 0);
      end else begin
        want = expected_settings.pop_front();
        if (m_code_o !== want.m_code) report_mismatch("m_code", m_code_o, want.m_code);
        if (n_code_o !== want.n_code) report_mismatch("n_code", n_code_o, want.n_code);
        if (p_code_o !== want.p_code) report_mismatch("p_code", p_code_o, want.p_code);
        if (actual_clock_o !== want.actual_clock)
          report_mismatch("actual_clock", actual_clock_o, want.actual_clock);
        if (search_status_o !== want.search_status)
          report_mismatch("search_status", search_status_o, want.search_status);
      end
    end
  end

  // Ends the run if no transaction completes on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic [PixW-1:0] pix, logic [SpaceW-1:0] space);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_clock_khz_i <= pix;
    colour_space_i <= space;
    do @(posedge clk_i); while (in_stall_o);
    expected_settings.push_back(search_divider(pix, space));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_settings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FreqW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRefFreq: ref_freq_q = data;
      RegMinVco:  min_vco_q = data;
      RegMax8:    max8_q = data;
      RegMax16:   max16_q = data;
      RegMax24:   max24_q = data;
      RegChipCls: class_q = data[ClassW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [FreqW-1:0] rf, logic [FreqW-1:0] mn, logic [FreqW-1:0] m8,
                         logic [FreqW-1:0] m16, logic [FreqW-1:0] m24, logic [FreqW-1:0] cls);
    drain();
    write_reg(RegRefFreq, rf);
    write_reg(RegMinVco, mn);
    write_reg(RegMax8, m8);
    write_reg(RegMax16, m16);
    write_reg(RegMax24, m24);
    write_reg(RegChipCls, cls);
  endtask

  task automatic test_reset_defaults;
    send_request('0, 2'd0);
    send_request({PixW{1'b1}}, 2'd1);
    send_request(19'd25175, 2'd2);
    send_request(19'd65000, 2'd3);
  endtask

  task automatic test_chip_classes;
    for (int c = 0; c < 4; c++) begin
      set_all(29'd14318 << 10, '0, FreqMax, FreqMax, FreqMax, FreqW'(c));
      send_request(19'd25175, 2'd0);
      send_request(19'd135000, 2'd3);
      send_request(19'd500, 2'd1);
    end
  endtask

  task automatic test_special_cases;
    // A zero reference can never give a pair.
    set_all('0, '0, FreqMax, FreqMax, FreqMax, FreqW'(ClassWide));
    send_request(19'd40000, 2'd2);
    // The colour-space maximum wins over a higher minimum.
    set_all(29'd14318 << 10, 29'd200000 << 10,
            29'd30000 << 10, 29'd50000 << 10, 29'd80000 << 10, FreqW'(ClassNarrow64));
    send_request(19'd1000, 2'd0);
    send_request(19'd1000, 2'd1);
    send_request(19'd1000, 2'd3);
    // Largest reference: saturated clock or no pair at all.
    set_all(FreqMax, '0, FreqMax, FreqMax, FreqMax, FreqW'(ClassWide));
    send_request({PixW{1'b1}}, 2'd3);
    send_request(19'd1, 2'd0);
    // Smallest reference, with every maximum at zero: n rounds to zero, no pair.
    set_all(29'd1, FreqMax, '0, '0, '0, FreqW'(ClassNarrow32));
    send_request(19'd7, 2'd2);
    send_request({PixW{1'b1}}, 2'd0);
  endtask

  task automatic test_random_requests(int unsigned count);
    logic [FreqW-1:0] rf;
    for (int g = 0; g < 6; g++) begin
      rf = ($urandom_range(3) == 0) ? FreqW'($urandom) :
                                      FreqW'($urandom_range(2000, 60000) << 10);
      set_all(rf,
              ($urandom_range(2) == 0) ? FreqW'($urandom) :
                                         FreqW'($urandom_range(0, 20000) << 10),
              ($urandom_range(3) == 0) ? FreqW'($urandom) :
                                         FreqW'($urandom_range(20000, 400000) << 10),
              ($urandom_range(3) == 0) ? FreqW'($urandom) :
                                         FreqW'($urandom_range(20000, 400000) << 10),
              ($urandom_range(3) == 0) ? FreqW'($urandom) :
                                         FreqW'($urandom_range(20000, 400000) << 10),
              FreqW'($urandom_range(3)));
      case (g)
        0, 1: begin send_idle_pct = 37; recv_idle_pct = 53; end
        2, 3: begin send_idle_pct = 53; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < count; i++) begin
        send_request(($urandom_range(1) == 0) ? PixW'($urandom) :
                                                PixW'($urandom_range(0, 400000)),
                     SpaceW'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_clock_khz_i = '0;
    colour_space_i = '0;
    out_stall_i = 1'b0;
    mismatches = 0;
    send_idle_pct = 37;
    recv_idle_pct = 53;
    ref_freq_q = RefFreqReset;
    min_vco_q = '0;
    max8_q = FreqMax;
    max16_q = FreqMax;
    max24_q = FreqMax;
    class_q = ClassWide;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_chip_classes();
    test_special_cases();
    test_random_requests(44);

    drain();
    repeat (2500) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
